>>> hw/rtl/connection_force_solver_top_macros.svh
// assertion helpers used by the checker file
`ifndef CONNECTION_FORCE_SOLVER_TOP_MACROS_SVH
`define CONNECTION_FORCE_SOLVER_TOP_MACROS_SVH

// condition in the cycle after a trigger, checked through reset as well
`define CFS_ASSERT_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) pre |=> post) \
      else $error("connection force check failed");

// same-cycle implication, off while reset is high
`define CFS_ASSERT_HOLD(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) pre |-> post) \
      else $error("connection force check failed");

`endif

>>> hw/rtl/cfs_pkg.sv
package cfs_pkg;

   localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] Q_ONE     = 64'h0000_0001_0000_0000;
   localparam logic [63:0] Q_HALF    = 64'h0000_0000_8000_0000;
   localparam logic [63:0] Q_QUARTER = 64'h0000_0000_4000_0000;

   localparam logic [1:0] LINK_RIGID = 2'd0;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_DZ = 2'd1;
   localparam logic [1:0] STATUS_OV = 2'd2;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 18;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  SAMPLE_RATE_RESET = 18'd44100;

   // quotient bits of (|a| << 32) / |b|, retired two per stage
   localparam int unsigned DIV_BITS   = 96;
   localparam int unsigned DIV_STEP   = 2;
   localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEP;

   typedef struct packed {
      logic [1:0]         link_kind;
      logic signed [63:0] first_next;
      logic signed [63:0] first_now;
      logic signed [63:0] first_before;
      logic signed [63:0] second_next;
      logic signed [63:0] second_now;
      logic signed [63:0] second_before;
      logic signed [63:0] first_div_term;
      logic signed [63:0] second_div_term;
      logic signed [63:0] linear_stiffness;
      logic signed [63:0] cubic_stiffness;
      logic signed [63:0] damping;
   } cfs_req_type;

   typedef struct packed {
      logic signed [63:0] force_res;
      logic [1:0]         status;
   } cfs_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        enabled;
      logic        rigid;
      logic        ov_front;
      logic [63:0] eta_next;
      logic [63:0] eta;
      logic [63:0] eta_prev;
      logic [63:0] dsum;
      logic [63:0] k1;
      logic [63:0] k3;
      logic [63:0] damp;
      logic [63:0] half_fs;
   } cfs_job_type;

   // context travelling with an item through the back pipeline
   typedef struct packed {
      logic        enabled;
      logic        rigid;
      logic        ov_front;
      logic        ov;
      logic        dz;
      logic [63:0] eta_next;
      logic [63:0] eta;
      logic [63:0] eta_prev;
      logic [63:0] dsum;
      logic [63:0] k1;
      logic [63:0] k3;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
   } cfs_ctx_type;

   typedef struct packed {
      logic        dz;
      logic        ov;
      logic [63:0] v;
   } cfs_qres_type;

   function automatic logic [63:0] q_mag(input logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   function automatic cfs_qres_type q_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0]  s;
      cfs_qres_type r;
      s    = a + b;
      r.dz = 1'b0;
      r.ov = 1'b0;
      r.v  = s;
      if (a[63] == b[63] && s[63] != a[63]) begin
         r.ov = 1'b1;
         r.v  = a[63] ? Q_MIN : Q_MAX;
      end
      return r;
   endfunction

   function automatic cfs_qres_type q_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0]  s;
      cfs_qres_type r;
      s    = a - b;
      r.dz = 1'b0;
      r.ov = 1'b0;
      r.v  = s;
      if (a[63] != b[63] && s[63] != a[63]) begin
         r.ov = 1'b1;
         r.v  = a[63] ? Q_MIN : Q_MAX;
      end
      return r;
   endfunction

   // signed result from sign and magnitude, saturating
   function automatic cfs_qres_type q_from_mag(input logic neg, input logic hi_nz,
                                               input logic [63:0] lo);
      cfs_qres_type r;
      r.dz = 1'b0;
      r.ov = 1'b0;
      if (neg) begin
         if (hi_nz || lo > Q_MIN) begin
            r.ov = 1'b1;
            r.v  = Q_MIN;
         end else begin
            r.v = 64'd0 - lo;
         end
      end else begin
         if (hi_nz || lo >= Q_MIN) begin
            r.ov = 1'b1;
            r.v  = Q_MAX;
         end else begin
            r.v = lo;
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/connection_force_solver_top.sv
// connection force solver: one spring or rigid connection per item
// request channel: an item is taken at a clock edge with start high and busy low;
//   req_data carries link kind, six point displacements, two division terms
//   and the K1, K3, R coefficients, all signed Q32.32
// response channel: rsp_valid strobes for one cycle with rsp_data (force and
//   status); the receiver cannot hold results off, so none is ever kept back
// csr port: csr_we writes csr_wdata into register csr_index at the clock edge
//   (index 0 sample rate, index 1 solving enable), no wait, no read-back
// throughput: one item per cycle, sustained; busy only rises if the queue
//   between front and back fills, which a free-running back never lets happen
// from the accepting edge to the strobe an item passes through the
//   chain of four-stage multipliers and two 50-stage divider pipelines
//   (48 stages of two quotient bits plus entry and saturation stages)
// reset: synchronous, clears every valid bit, the queue and restores the
//   sample rate to 44100 and solving enabled; in-flight items are dropped
// items stay in order; disabled solving gives zero force with ok status
module connection_force_solver_top import cfs_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cfs_req_type            req_data,
   output logic                   rsp_valid,
   output cfs_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   logic [CSR_DATA_W-1:0] sample_rate_ff;
   logic                  enabled_ff;
   logic                  accept;
   logic                  front_valid;
   cfs_job_type           front_job;
   logic                  queue_valid;
   cfs_job_type           queue_job;
   logic [CNT_W-1:0]      queue_level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SAMPLE_RATE_RESET;
         enabled_ff     <= 1'b1;
      end else if (csr_we) begin
         if (csr_index == CSR_SAMPLE_RATE) begin
            sample_rate_ff <= csr_wdata;
         end
         if (csr_index == CSR_ENABLE) begin
            enabled_ff <= csr_wdata[0];
         end
      end
   end

   // hold off only when the queue plus the item in the front would overflow it;
   // the head leaves in every cycle that the queue holds one, so a push and a pop can share an edge
   assign busy = ({1'b0, queue_level} + {{CNT_W{1'b0}}, front_valid})
               > (CNT_W+1)'(QUEUE_DEPTH);
   assign accept = start && !busy;

   // front: take the item, form relative displacements, classify the link
   cfs_front u_front (
      .clock, .reset, .accept(accept), .req(req_data),
      .sample_rate(sample_rate_ff), .enabled(enabled_ff),
      .out_valid(front_valid), .out_job(front_job));

   // short queue between front and back
   cfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push(front_valid), .push_job(front_job),
      .out_valid(queue_valid), .out_job(queue_job), .level(queue_level));

   // back: spring terms, divisions and the force itself
   cfs_back u_back (
      .clock, .reset, .in_valid(queue_valid), .in_job(queue_job),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data));

endmodule

>>> hw/rtl/cfs_front.sv
module cfs_front import cfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cfs_req_type           req,
   input  logic [CSR_DATA_W-1:0] sample_rate,
   input  logic                  enabled,
   output logic                  out_valid,
   output cfs_job_type           out_job
);

   logic        valid_ff;
   cfs_job_type job_ff, job_in;

   always_comb begin
      cfs_qres_type en, e, ep, ds;
      en = q_sub(req.first_next, req.second_next);
      e  = q_sub(req.first_now, req.second_now);
      ep = q_sub(req.first_before, req.second_before);
      ds = q_add(req.first_div_term, req.second_div_term);
      job_in.enabled  = enabled;
      job_in.rigid    = (req.link_kind == LINK_RIGID);
      job_in.ov_front = en.ov | e.ov | ep.ov | ds.ov;
      job_in.eta_next = en.v;
      job_in.eta      = e.v;
      job_in.eta_prev = ep.v;
      job_in.dsum     = ds.v;
      job_in.k1       = req.linear_stiffness;
      job_in.k3       = req.cubic_stiffness;
      job_in.damp     = req.damping;
      // fs / 2 in Q32.32
      job_in.half_fs  = {15'd0, sample_rate, 31'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;

endmodule

>>> hw/rtl/cfs_queue.sv
module cfs_queue import cfs_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  cfs_job_type                  push_job,
   output logic                         out_valid,
   output cfs_job_type                  out_job,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

   cfs_job_type       mem_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   // the back never stalls, so the head leaves whenever present
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign out_valid = pop;
   assign out_job   = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

>>> hw/rtl/cfs_mul.sv
module cfs_mul import cfs_pkg::*; #(
   parameter int unsigned TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [63:0]      a,
   input  logic [63:0]      b,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output cfs_qres_type     out_res,
   output logic [TAG_W-1:0] out_tag
);

   // magnitudes, 32x32 partial products, sum, saturate
   logic [3:0]       valid_ff;
   logic [TAG_W-1:0] tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]      ma_ff, mb_ff;
   logic [63:0]      p0_ff, p1_ff, p2_ff, p3_ff;
   logic [127:0]     sum_ff, sum_in;
   cfs_qres_type     res_ff;

   assign sum_in = {64'd0, p0_ff} + {32'd0, p1_ff, 32'd0} + {32'd0, p2_ff, 32'd0}
                 + {p3_ff, 64'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      neg1_ff <= a[63] ^ b[63];
      ma_ff   <= q_mag(a);
      mb_ff   <= q_mag(b);
      tag1_ff <= in_tag;
      p0_ff   <= ma_ff[31:0]  * mb_ff[31:0];
      p1_ff   <= ma_ff[31:0]  * mb_ff[63:32];
      p2_ff   <= ma_ff[63:32] * mb_ff[31:0];
      p3_ff   <= ma_ff[63:32] * mb_ff[63:32];
      neg2_ff <= neg1_ff;
      tag2_ff <= tag1_ff;
      sum_ff  <= sum_in;
      neg3_ff <= neg2_ff;
      tag3_ff <= tag2_ff;
      res_ff  <= q_from_mag(neg3_ff, |sum_ff[127:96], sum_ff[95:32]);
      tag4_ff <= tag3_ff;
   end

   assign out_valid = valid_ff[3];
   assign out_res   = res_ff;
   assign out_tag   = tag4_ff;

endmodule

>>> hw/rtl/cfs_div.sv
module cfs_div import cfs_pkg::*; #(
   parameter int unsigned TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [63:0]      a,
   input  logic [63:0]      b,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output cfs_qres_type     out_res,
   output logic [TAG_W-1:0] out_tag
);

   // restoring division, DIV_STEP quotient bits per stage
   logic [DIV_BITS-1:0] num_ff [DIV_STAGES+1];
   logic [DIV_BITS-1:0] num_in [DIV_STAGES+1];
   logic [DIV_BITS-1:0] quo_ff [DIV_STAGES+1];
   logic [DIV_BITS-1:0] quo_in [DIV_STAGES+1];
   logic [63:0]         rem_ff [DIV_STAGES+1];
   logic [63:0]         rem_in [DIV_STAGES+1];
   logic [63:0]         mb_ff  [DIV_STAGES+1];
   logic [3:0]          meta_ff [DIV_STAGES+1];
   logic [TAG_W-1:0]    tag_ff [DIV_STAGES+1];
   logic [DIV_STAGES:0] valid_ff;
   logic                out_valid_ff;
   cfs_qres_type        res_ff, res_in;
   logic [TAG_W-1:0]    out_tag_ff;

   // meta: quotient sign, divisor zero, dividend zero, dividend sign
   always_comb begin
      logic [63:0]         r;
      logic [DIV_BITS-1:0] n;
      logic [DIV_BITS-1:0] q;
      num_in[0] = {q_mag(a), 32'd0};
      quo_in[0] = '0;
      rem_in[0] = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         r = rem_ff[k];
         n = num_ff[k];
         q = quo_ff[k];
         for (int j = 0; j < DIV_STEP; j++) begin
            r = {r[62:0], n[DIV_BITS-1]};
            n = {n[DIV_BITS-2:0], 1'b0};
            if (r >= mb_ff[k]) begin
               r = r - mb_ff[k];
               q = {q[DIV_BITS-2:0], 1'b1};
            end else begin
               q = {q[DIV_BITS-2:0], 1'b0};
            end
         end
         rem_in[k+1] = r;
         num_in[k+1] = n;
         quo_in[k+1] = q;
      end
   end

   always_comb begin
      logic [3:0]          m;
      logic [DIV_BITS-1:0] q;
      m = meta_ff[DIV_STAGES];
      q = quo_ff[DIV_STAGES];
      if (m[2]) begin
         res_in.dz = 1'b1;
         res_in.ov = 1'b0;
         res_in.v  = m[1] ? 64'd0 : (m[0] ? Q_MIN : Q_MAX);
      end else begin
         res_in = q_from_mag(m[3], |q[DIV_BITS-1:64], q[63:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[DIV_STAGES-1:0], in_valid};
         out_valid_ff <= valid_ff[DIV_STAGES];
      end
      num_ff[0]  <= num_in[0];
      quo_ff[0]  <= quo_in[0];
      rem_ff[0]  <= rem_in[0];
      mb_ff[0]   <= q_mag(b);
      meta_ff[0] <= {a[63] ^ b[63], (b == 64'd0), (a == 64'd0), a[63]};
      tag_ff[0]  <= in_tag;
      for (int k = 0; k < DIV_STAGES; k++) begin
         num_ff[k+1]  <= num_in[k+1];
         quo_ff[k+1]  <= quo_in[k+1];
         rem_ff[k+1]  <= rem_in[k+1];
         mb_ff[k+1]   <= mb_ff[k];
         meta_ff[k+1] <= meta_ff[k];
         tag_ff[k+1]  <= tag_ff[k];
      end
      res_ff     <= res_in;
      out_tag_ff <= tag_ff[DIV_STAGES];
   end

   assign out_valid = out_valid_ff;
   assign out_res   = res_ff;
   assign out_tag   = out_tag_ff;

endmodule

>>> hw/rtl/cfs_back.sv
module cfs_back import cfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  cfs_job_type in_job,
   output logic        rsp_valid,
   output cfs_rsp_type rsp_data
);

   localparam int unsigned CTX_W = $bits(cfs_ctx_type);

   cfs_ctx_type  ctx_a, ctx_b, ctx_c, tag_a, tag_b, tag_c, tag_e, tag_f, tag_h;
   cfs_ctx_type  ctx_f, ctx_h;
   cfs_ctx_type  d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   cfs_ctx_type  g1_ff, g1_in, g2_ff, g2_in;
   logic         va, vb, vc, ve, vf, vh;
   logic         d1_valid_ff, d2_valid_ff, d3_valid_ff, g1_valid_ff, g2_valid_ff;
   logic         out_valid_ff;
   cfs_rsp_type  out_ff, out_in;
   cfs_qres_type ee, qk1, dterm, ke, he, q1, q2, inv, t1, t2, fin;
   logic [63:0]  div_a, div_b;

   always_comb begin
      ctx_a          = '0;
      ctx_a.enabled  = in_job.enabled;
      ctx_a.rigid    = in_job.rigid;
      ctx_a.ov_front = in_job.ov_front;
      ctx_a.ov       = in_job.ov_front;
      ctx_a.eta_next = in_job.eta_next;
      ctx_a.eta      = in_job.eta;
      ctx_a.eta_prev = in_job.eta_prev;
      ctx_a.dsum     = in_job.dsum;
      ctx_a.k1       = in_job.k1;
      ctx_a.k3       = in_job.k3;
   end

   // eta squared, K1/4 and fs*R/2
   cfs_mul #(.TAG_W(CTX_W)) u_mul_ee (
      .clock, .reset, .in_valid(in_valid), .a(in_job.eta), .b(in_job.eta),
      .in_tag(ctx_a), .out_valid(va), .out_res(ee), .out_tag(tag_a));
   cfs_mul #(.TAG_W(1)) u_mul_k1 (
      .clock, .reset, .in_valid(in_valid), .a(Q_QUARTER), .b(in_job.k1),
      .in_tag(1'b0), .out_valid(), .out_res(qk1), .out_tag());
   cfs_mul #(.TAG_W(1)) u_mul_damp (
      .clock, .reset, .in_valid(in_valid), .a(in_job.damp), .b(in_job.half_fs),
      .in_tag(1'b0), .out_valid(), .out_res(dterm), .out_tag());

   always_comb begin
      ctx_b    = tag_a;
      ctx_b.x  = qk1.v;
      ctx_b.y  = dterm.v;
      ctx_b.ov = tag_a.ov | ee.ov | qk1.ov | dterm.ov;
   end

   cfs_mul #(.TAG_W(CTX_W)) u_mul_k3 (
      .clock, .reset, .in_valid(va), .a(tag_a.k3), .b(ee.v),
      .in_tag(ctx_b), .out_valid(vb), .out_res(ke), .out_tag(tag_b));

   always_comb begin
      ctx_c    = tag_b;
      ctx_c.ov = tag_b.ov | ke.ov;
   end

   cfs_mul #(.TAG_W(CTX_W)) u_mul_half (
      .clock, .reset, .in_valid(vb), .a(Q_HALF), .b(ke.v),
      .in_tag(ctx_c), .out_valid(vc), .out_res(he), .out_tag(tag_c));

   // base, then rPlus and rMin, then 2*rPlus
   always_comb begin
      cfs_qres_type s;
      s        = q_add(tag_c.x, he.v);
      d1_in    = tag_c;
      d1_in.x  = s.v;
      d1_in.ov = tag_c.ov | he.ov | s.ov;
   end

   always_comb begin
      cfs_qres_type rp, rm;
      rp       = q_add(d1_ff.x, d1_ff.y);
      rm       = q_sub(d1_ff.x, d1_ff.y);
      d2_in    = d1_ff;
      d2_in.x  = rp.v;
      d2_in.y  = rm.v;
      d2_in.ov = d1_ff.ov | rp.ov | rm.ov;
   end

   always_comb begin
      cfs_qres_type rp2;
      rp2      = q_add(d2_ff.x, d2_ff.x);
      d3_in    = d2_ff;
      d3_in.z  = rp2.v;
      d3_in.ov = d2_ff.ov | rp2.ov;
   end

   cfs_div #(.TAG_W(CTX_W)) u_div_k1 (
      .clock, .reset, .in_valid(d3_valid_ff), .a(d3_ff.k1), .b(d3_ff.z),
      .in_tag(d3_ff), .out_valid(ve), .out_res(q1), .out_tag(tag_e));
   cfs_div #(.TAG_W(1)) u_div_rmin (
      .clock, .reset, .in_valid(d3_valid_ff), .a(d3_ff.y), .b(d3_ff.x),
      .in_tag(1'b0), .out_valid(), .out_res(q2), .out_tag());
   cfs_div #(.TAG_W(1)) u_div_inv (
      .clock, .reset, .in_valid(d3_valid_ff), .a(Q_ONE), .b(d3_ff.x),
      .in_tag(1'b0), .out_valid(), .out_res(inv), .out_tag());

   // denominator rides along with the two products
   always_comb begin
      cfs_qres_type den;
      den      = q_add(inv.v, tag_e.dsum);
      ctx_f    = tag_e;
      ctx_f.x  = den.v;
      ctx_f.ov = tag_e.ov | q1.ov | q2.ov | inv.ov | den.ov;
      ctx_f.dz = tag_e.dz | q1.dz | q2.dz | inv.dz;
   end

   cfs_mul #(.TAG_W(CTX_W)) u_mul_t1 (
      .clock, .reset, .in_valid(ve), .a(q1.v), .b(tag_e.eta),
      .in_tag(ctx_f), .out_valid(vf), .out_res(t1), .out_tag(tag_f));
   cfs_mul #(.TAG_W(1)) u_mul_t2 (
      .clock, .reset, .in_valid(ve), .a(q2.v), .b(tag_e.eta_prev),
      .in_tag(1'b0), .out_valid(), .out_res(t2), .out_tag());

   always_comb begin
      cfs_qres_type s1;
      s1       = q_add(tag_f.eta_next, t1.v);
      g1_in    = tag_f;
      g1_in.y  = s1.v;
      g1_in.z  = t2.v;
      g1_in.ov = tag_f.ov | t1.ov | t2.ov | s1.ov;
   end

   always_comb begin
      cfs_qres_type num;
      num      = q_add(g1_ff.y, g1_ff.z);
      g2_in    = g1_ff;
      g2_in.y  = num.v;
      g2_in.ov = g1_ff.ov | num.ov;
   end

   // rigid links share the final divider
   always_comb begin
      ctx_h = g2_ff;
      if (g2_ff.rigid) begin
         div_a = g2_ff.eta_next;
         div_b = g2_ff.dsum;
      end else begin
         div_a = g2_ff.y;
         div_b = g2_ff.x;
      end
   end

   cfs_div #(.TAG_W(CTX_W)) u_div_force (
      .clock, .reset, .in_valid(g2_valid_ff), .a(div_a), .b(div_b),
      .in_tag(ctx_h), .out_valid(vh), .out_res(fin), .out_tag(tag_h));

   always_comb begin
      logic dz, ov;
      dz = fin.dz | (!tag_h.rigid && tag_h.dz);
      ov = fin.ov | (tag_h.rigid ? tag_h.ov_front : tag_h.ov);
      if (!tag_h.enabled) begin
         out_in.force_res = '0;
         out_in.status    = STATUS_OK;
      end else begin
         out_in.force_res = fin.v;
         priority if (dz) begin
            out_in.status = STATUS_DZ;
         end else if (ov) begin
            out_in.status = STATUS_OV;
         end else begin
            out_in.status = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         d3_valid_ff  <= 1'b0;
         g1_valid_ff  <= 1'b0;
         g2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         d1_valid_ff  <= vc;
         d2_valid_ff  <= d1_valid_ff;
         d3_valid_ff  <= d2_valid_ff;
         g1_valid_ff  <= vf;
         g2_valid_ff  <= g1_valid_ff;
         out_valid_ff <= vh;
      end
      d1_ff  <= d1_in;
      d2_ff  <= d2_in;
      d3_ff  <= d3_in;
      g1_ff  <= g1_in;
      g2_ff  <= g2_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> hw/rtl/cfs_checker.sv
`include "connection_force_solver_top_macros.svh"

module cfs_checker import cfs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input cfs_rsp_type rsp_data
);

   // nothing leaves the pipeline right after reset
   `CFS_ASSERT_NEXT(a_no_rsp_after_reset, clock, reset, !rsp_valid)
   // the queue comes out of reset empty and ready
   `CFS_ASSERT_NEXT(a_ready_after_reset, clock, reset, !busy)
   // only the three defined status codes appear
   `CFS_ASSERT_HOLD(a_status_code, clock, reset, rsp_valid, (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_DZ || rsp_data.status == STATUS_OV))

endmodule

bind connection_force_solver_top cfs_checker u_cfs_checker (
   .clock(clock),
   .reset(reset),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);

>>> verif/connection_force_solver_top_test.sv
module connection_force_solver_top_test;
   import cfs_pkg::*;

   localparam int unsigned LATENCY     = 124;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASE_ITEMS = 122;
   localparam logic [1:0]  LINK_LINEAR = 2'd1;
   localparam logic [1:0]  LINK_CUBIC  = 2'd2;
   localparam logic [1:0]  LINK_SPARE  = 2'd3;

   // expected forces, in order, plus the bit-exact fixed point force model
   class force_scoreboard;
      logic [17:0] rate;
      logic        enabled;
      bit          dz;
      bit          ov;
      cfs_rsp_type forces_due[$];
      int          errors;

      function new();
         rate    = SAMPLE_RATE_RESET;
         enabled = 1'b1;
         errors  = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      function logic [63:0] magnitude(input logic [63:0] x);
         return x[63] ? (~x + 64'd1) : x;
      endfunction

      // signed value from sign and wide magnitude, clamped to the q range
      function logic [63:0] clamp(input bit neg, input logic [127:0] m);
         if (neg) begin
            if (m > {64'd0, Q_MIN}) begin
               ov = 1'b1;
               return Q_MIN;
            end
            return 64'd0 - m[63:0];
         end
         if (m >= {64'd0, Q_MIN}) begin
            ov = 1'b1;
            return Q_MAX;
         end
         return m[63:0];
      endfunction

      function logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63]) begin
            ov = 1'b1;
            return a[63] ? Q_MIN : Q_MAX;
         end
         return s;
      endfunction

      function logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] s;
         s = a - b;
         if (a[63] != b[63] && s[63] != a[63]) begin
            ov = 1'b1;
            return a[63] ? Q_MIN : Q_MAX;
         end
         return s;
      endfunction

      function logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
         return clamp(a[63] ^ b[63], p >> 32);
      endfunction

      function logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
         logic [127:0] q;
         if (b == 64'd0) begin
            dz = 1'b1;
            if (a == 64'd0) return 64'd0;
            return a[63] ? Q_MIN : Q_MAX;
         end
         q = ({64'd0, magnitude(a)} << 32) / {64'd0, magnitude(b)};
         return clamp(a[63] ^ b[63], q);
      endfunction

      function cfs_rsp_type connection_force(input cfs_req_type r);
         cfs_rsp_type o;
         logic [63:0] en, e, ep, dsum, half_fs, base, dterm, rp, rm, t1, t2, num, den;
         dz = 1'b0;
         ov = 1'b0;
         o.force_res = 64'd0;
         o.status    = STATUS_OK;
         if (!enabled) return o;
         en   = sat_sub(r.first_next, r.second_next);
         e    = sat_sub(r.first_now, r.second_now);
         ep   = sat_sub(r.first_before, r.second_before);
         dsum = sat_add(r.first_div_term, r.second_div_term);
         if (r.link_kind == LINK_RIGID) begin
            o.force_res = fx_div(en, dsum);
         end else begin
            half_fs = {46'd0, rate} << 31;
            base  = sat_add(fx_mul(Q_QUARTER, r.linear_stiffness),
                            fx_mul(Q_HALF, fx_mul(r.cubic_stiffness, fx_mul(e, e))));
            dterm = fx_mul(r.damping, half_fs);
            rp    = sat_add(base, dterm);
            rm    = sat_sub(base, dterm);
            t1    = fx_mul(fx_div(r.linear_stiffness, sat_add(rp, rp)), e);
            t2    = fx_mul(fx_div(rm, rp), ep);
            num   = sat_add(sat_add(en, t1), t2);
            den   = sat_add(fx_div(Q_ONE, rp), dsum);
            o.force_res = fx_div(num, den);
         end
         o.status = dz ? STATUS_DZ : (ov ? STATUS_OV : STATUS_OK);
         return o;
      endfunction

      function void note_item(input cfs_req_type r);
         forces_due = {forces_due, connection_force(r)};
      endfunction

      task check_result(input cfs_rsp_type got);
         cfs_rsp_type want;
         if (forces_due.size() == 0) begin
            report($sformatf("result with nothing pending, force %h", got.force_res));
         end else begin
            want = forces_due.pop_front();
            if (got.force_res !== want.force_res)
               report($sformatf("force %h, predicted %h", got.force_res, want.force_res));
            if (got.status !== want.status)
               report($sformatf("status %0d, predicted %0d", got.status, want.status));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   cfs_req_type            req_data = '0;
   logic                   rsp_valid;
   cfs_rsp_type            rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SAMPLE_RATE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   force_scoreboard sb = new();
   int unsigned     cycles = 0;
   bit              allow_gaps = 1'b1;

   connection_force_solver_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // watch both channels and the csr port at each edge, pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            // register writes take effect for items accepted afterward
            if (csr_index == CSR_SAMPLE_RATE) sb.rate = csr_wdata;
            else if (csr_index == CSR_ENABLE) sb.enabled = csr_wdata[0];
         end
         if (start && !busy) sb.note_item(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("connection_force_solver_top_test: done, errors");
         $finish;
      end
   end

   // offer one item and hold it until the block takes it
   task send_item(input cfs_req_type item);
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      // random idle burst between items, none late in the run
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // wait for every predicted force, then let the pipeline settle
   task drain();
      start <= 1'b0;
      while (sb.forces_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfs_req_type make_item(input logic [1:0] kind,
         input logic [63:0] fn, input logic [63:0] fw, input logic [63:0] fb,
         input logic [63:0] sn, input logic [63:0] sw, input logic [63:0] sbf,
         input logic [63:0] d1, input logic [63:0] d2, input logic [63:0] k1,
         input logic [63:0] k3, input logic [63:0] r);
      cfs_req_type it;
      it = '{kind, fn, fw, fb, sn, sw, sbf, d1, d2, k1, k3, r};
      return it;
   endfunction

   // mostly small physical values, some raw bit patterns and extremes
   function automatic logic [63:0] rand_q();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return raw;
         1: begin
            case ($urandom_range(0, 4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 64'd0;
               3: return Q_ONE;
               default: return 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
         2: return {{40{raw[23]}}, raw[23:0]};
         default: return {{24{raw[39]}}, raw[39:0]};
      endcase
   endfunction

   function automatic cfs_req_type rand_item();
      logic [1:0] kind;
      kind = ($urandom_range(0, 15) == 0) ? LINK_SPARE : 2'($urandom_range(0, 2));
      return make_item(kind, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q(), rand_q(), rand_q(),
                       (kind == LINK_LINEAR) ? 64'd0 : rand_q(), rand_q());
   endfunction

   task directed_items();
      logic [63:0] q2;
      q2 = Q_ONE << 1;
      // rigid link, plain case
      send_item(make_item(LINK_RIGID, Q_ONE, 0, 0, 0, 0, 0, Q_ONE, Q_ONE, 0, 0, 0));
      // rigid link, division terms cancel: division by zero
      send_item(make_item(LINK_RIGID, Q_ONE, 0, 0, 0, 0, 0, Q_ONE, -Q_ONE, 0, 0, 0));
      send_item(make_item(LINK_RIGID, -Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // zero over zero
      send_item(make_item(LINK_RIGID, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // relative displacement overflows
      send_item(make_item(LINK_RIGID, Q_MAX, 0, 0, Q_MIN, 0, 0, Q_ONE, 0, 0, 0, 0));
      send_item(make_item(LINK_RIGID, Q_MIN, 0, 0, Q_MAX, 0, 0, Q_ONE, 0, 0, 0, 0));
      // tiny divisor: quotient overflow
      send_item(make_item(LINK_RIGID, Q_MAX, 0, 0, 0, 0, 0, 64'd1, 0, 0, 0, 0));
      // linear and nonlinear springs with modest values
      send_item(make_item(LINK_LINEAR, Q_ONE, Q_HALF, Q_QUARTER, 0, 0, 0,
                          Q_ONE, Q_ONE, q2, 0, Q_QUARTER >> 8));
      send_item(make_item(LINK_CUBIC, Q_ONE, Q_HALF, -Q_HALF, Q_QUARTER, -Q_QUARTER, 0,
                          Q_HALF, Q_ONE, q2, q2, Q_QUARTER >> 10));
      // unused link kind runs as a spring
      send_item(make_item(LINK_SPARE, Q_ONE, Q_HALF, Q_QUARTER, 0, 0, 0,
                          Q_ONE, Q_ONE, q2, Q_ONE, -(Q_QUARTER >> 8)));
      // spring with all zero: rPlus zero
      send_item(make_item(LINK_LINEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // field extremes
      send_item(make_item(LINK_CUBIC, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                          Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_item(make_item(LINK_CUBIC, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                          Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_item(make_item(LINK_SPARE, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                          Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      send_item(make_item(LINK_CUBIC, '1, '1, '1, 0, 0, 0, '1, '1, '1, '1, '1));
      // huge damping against the sample rate
      send_item(make_item(LINK_LINEAR, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0,
                          Q_ONE, Q_ONE, Q_ONE, 0, Q_MAX));
   endtask

   task random_items(input int unsigned count);
      repeat (count) send_item(rand_item());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: 44100 hertz, solving on
      directed_items();
      random_items(PHASE_ITEMS);
      drain();

      // sample rate extremes, legal and beyond the legal range
      write_reg(CSR_SAMPLE_RATE, 18'd8000);
      random_items(PHASE_ITEMS);
      drain();
      write_reg(CSR_SAMPLE_RATE, 18'd192000);
      random_items(PHASE_ITEMS);
      drain();
      write_reg(CSR_SAMPLE_RATE, '1);
      random_items(PHASE_ITEMS / 2);
      drain();
      write_reg(CSR_SAMPLE_RATE, '0);
      random_items(PHASE_ITEMS / 2);
      drain();
      write_reg(CSR_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
      random_items(PHASE_ITEMS);
      drain();

      // solving off: forces must read zero with ok status
      write_reg(CSR_ENABLE, 18'd0);
      write_reg(CSR_SAMPLE_RATE, 18'd96000);
      directed_items();
      random_items(PHASE_ITEMS / 2);
      drain();

      // back on, then a final stretch at full rate with no gaps
      write_reg(CSR_ENABLE, 18'd1);
      write_reg(CSR_SAMPLE_RATE, 18'd48000);
      random_items(PHASE_ITEMS);
      allow_gaps = 1'b0;
      random_items(PHASE_ITEMS);
      drain();
      repeat (LATENCY + 8) @(posedge clock);

      if (sb.errors == 0) begin
         $display("connection_force_solver_top_test: done, clean");
      end else begin
         $display("connection_force_solver_top_test: done, errors");
      end
      $finish;
   end
endmodule
